>>> rtl/stdp_pkg.sv
`default_nettype none
package stdp_pkg;

    localparam int unsigned TraceW = 24;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned RateW  = 24;
    localparam int unsigned OpW    = 2;
    localparam int unsigned SynW   = 10;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [TraceW-1:0] TraceMax = 24'hFFFFFF;
    localparam logic [TraceW-1:0] OneQ816  = 24'h010000;

    typedef enum logic [OpW-1:0] {
        OP_ADVANCE = 2'd0,
        OP_PRE     = 2'd1,
        OP_POST    = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PRE_RATE  = 2'd0,
        CFG_POST_RATE = 2'd1,
        CFG_ELIG_RATE = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch input item, issue memory read
        logic prod;      // register elapsed * rate products
        logic factor;    // register table factors
        logic decay;     // register trace * factor products
        logic commit;    // final values, write back, load output
        logic clear;     // clearing pass write
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_advance;
    } t_status;

    // exp(-i/64), unsigned Q1.23, built with the Q.32 accumulator recurrence
    function automatic logic [TraceW-1:0] exp_entry(input int unsigned idx);
        logic [63:0] acc;
        logic [63:0] ent;
        acc = 64'h1_0000_0000;
        for (int unsigned k = 0; k < idx; k++) begin
            acc = (acc * 64'd4228380000) >> 32;
        end
        ent = (acc + 64'd256) >> 9;
        return ent[TraceW-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/stdp_eligibility_traces_core.sv
`default_nettype none
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tdata: opcode, synapse, now_time
// m_axis    out  m_axis_tvalid / m_axis_tready    tdata: pre, post, pp_elig, post_pre
// cfg       in   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// Steps: spike items go through store read and write back; advance-time
// items go through read, elapsed*rate, table read, trace*factor, write back.
// An item is taken only when idle, so the next one waits for the last write back.
// Reset: a pass over max(NUM_SYNAPSES, EXP_TABLE_DEPTH) addresses zeroes the store
// and loads the exp tables; no item is accepted meanwhile. A finished result
// waits in the output register; the next item is taken once it is free or being emptied.
module stdp_eligibility_traces_core #(
    parameter int unsigned NUM_SYNAPSES    = 1024,
    parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] opcode, [11:2] synapse, [43:12] now_time, [47:44] zero
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [23:0] pre_trace, [47:24] post_trace, [71:48] pre-before-post eligibility,
    // [95:72] post_pre_elig
    output logic [95:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [stdp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [stdp_pkg::RateW-1:0]   i_cfg_data
);
    // reset pass covers both the synapse store and the exp tables
    localparam int unsigned ClrDepth = (NUM_SYNAPSES > EXP_TABLE_DEPTH) ?
                                       NUM_SYNAPSES : EXP_TABLE_DEPTH;
    localparam int unsigned CW = $clog2(ClrDepth);

    logic [stdp_pkg::RateW-1:0] r_pre_rate, r_post_rate, r_elig_rate;
    logic r_out_valid;
    logic w_out_free;
    stdp_pkg::t_cmd    w_cmd;
    stdp_pkg::t_status w_status;
    logic [CW-1:0]     w_clr_addr;
    logic [stdp_pkg::TraceW-1:0] w_pre, w_post, w_pp, w_ppr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_rate  <= 24'd16777;
            r_post_rate <= 24'd16777;
            r_elig_rate <= 24'd1678;
        end else if (i_cfg_valid) begin
            unique case (stdp_pkg::t_cfg_idx'(i_cfg_index))
                stdp_pkg::CFG_PRE_RATE:  r_pre_rate  <= i_cfg_data;
                stdp_pkg::CFG_POST_RATE: r_post_rate <= i_cfg_data;
                stdp_pkg::CFG_ELIG_RATE: r_elig_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    stdp_ctrl #(.CLR_DEPTH(ClrDepth)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_out_free(w_out_free),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_clr_addr(w_clr_addr)
    );

    stdp_dp #(
        .NUM_SYNAPSES   (NUM_SYNAPSES),
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
        .CLR_DEPTH      (ClrDepth)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_clr_addr (w_clr_addr),
        .i_opcode   (s_axis_tdata[1:0]),
        .i_synapse  (s_axis_tdata[11:2]),
        .i_now_time (s_axis_tdata[43:12]),
        .i_pre_rate (r_pre_rate),
        .i_post_rate(r_post_rate),
        .i_elig_rate(r_elig_rate),
        .o_pre      (w_pre),
        .o_post     (w_post),
        .o_pp_elig  (w_pp),
        .o_post_pre (w_ppr)
    );

    // output valid: set on commit, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {w_ppr, w_pp, w_post, w_pre};

    // no item is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> !s_axis_tready)
        else $error("item accepted while clearing");

    // a commit never overwrites a result still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!r_out_valid || m_axis_tready))
        else $error("result overrun");

    // each accepted item commits: a spike in the next cycle, an advance after the prod, factor and decay steps
    a_commit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> (w_cmd.commit or ##3 w_cmd.commit))
        else $error("accepted item lost");
endmodule
`default_nettype wire

>>> rtl/stdp_ram.sv
`default_nettype none
module stdp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/stdp_ctrl.sv
`default_nettype none
module stdp_ctrl #(
    parameter int unsigned CLR_DEPTH = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_free,
    input  wire stdp_pkg::t_status i_status,
    output stdp_pkg::t_cmd       o_cmd,
    output logic [$clog2(CLR_DEPTH)-1:0] o_clr_addr
);
    localparam int unsigned AW = $clog2(CLR_DEPTH);
    localparam logic [AW-1:0] LastAddr = AW'(CLR_DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_PROD   = 6'b001000,
        S_FACTOR = 6'b010000,
        S_DECAY  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == LastAddr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = i_out_free;
                if (i_in_valid && i_out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_status.is_advance) begin
                    o_cmd.prod = 1'b1;
                    n_state = S_PROD;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PROD: begin
                o_cmd.factor = 1'b1;
                n_state = S_FACTOR;
            end
            S_FACTOR: begin
                o_cmd.decay = 1'b1;
                n_state = S_DECAY;
            end
            S_DECAY: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_clr_addr = r_clr;
endmodule
`default_nettype wire

>>> rtl/stdp_dp.sv
`default_nettype none
module stdp_dp #(
    parameter int unsigned NUM_SYNAPSES    = 1024,
    parameter int unsigned EXP_TABLE_DEPTH = 1024,
    parameter int unsigned CLR_DEPTH       = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire stdp_pkg::t_cmd            i_cmd,
    output stdp_pkg::t_status              o_status,
    input  wire logic [$clog2(CLR_DEPTH)-1:0] i_clr_addr,
    input  wire logic [stdp_pkg::OpW-1:0]    i_opcode,
    input  wire logic [stdp_pkg::SynW-1:0]   i_synapse,
    input  wire logic [stdp_pkg::TimeW-1:0]  i_now_time,
    input  wire logic [stdp_pkg::RateW-1:0]  i_pre_rate,
    input  wire logic [stdp_pkg::RateW-1:0]  i_post_rate,
    input  wire logic [stdp_pkg::RateW-1:0]  i_elig_rate,
    output logic [stdp_pkg::TraceW-1:0]      o_pre,
    output logic [stdp_pkg::TraceW-1:0]      o_post,
    output logic [stdp_pkg::TraceW-1:0]      o_pp_elig,
    output logic [stdp_pkg::TraceW-1:0]      o_post_pre
);
    localparam int unsigned AW  = $clog2(NUM_SYNAPSES);
    localparam int unsigned TW  = stdp_pkg::TraceW;
    localparam int unsigned MW  = stdp_pkg::TimeW + 4 * TW; // time + four traces
    localparam int unsigned EAW = $clog2(EXP_TABLE_DEPTH);
    localparam int unsigned PW  = stdp_pkg::TimeW + stdp_pkg::RateW;
    localparam int unsigned CW  = $clog2(CLR_DEPTH);
    localparam logic [31:0] ExpStep = 32'd4228380000; // exp(-1/64), Q0.32

    // captured item
    logic [stdp_pkg::OpW-1:0]  r_op;
    logic [AW-1:0]             r_addr;
    logic                      r_oor;
    logic [stdp_pkg::TimeW-1:0] r_now;

    logic [MW-1:0] w_rdata, w_wdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;

    logic [stdp_pkg::TimeW-1:0] w_last;
    logic [TW-1:0] w_pre, w_post, w_pp, w_ppr;
    assign {w_last, w_pre, w_post, w_pp, w_ppr} = w_rdata;

    logic [stdp_pkg::TimeW-1:0] w_elapsed;
    logic [PW-1:0] r_x_pre, r_x_post, r_x_elig;
    logic          r_big_pre, r_big_post, r_big_elig;
    logic [TW-1:0] w_tab_pre, w_tab_post, w_tab_elig;
    logic [TW-1:0] w_f_pre, w_f_post, w_f_elig;
    logic [2*TW-1:0] r_d_pre, r_d_post, r_d_pp, r_d_ppr;
    logic [TW-1:0] n_pre, n_post, n_pp, n_ppr;
    logic          w_in_range;

    // exp table fill during the reset pass: Q.32 accumulator recurrence
    logic [32:0]   r_acc;
    logic [32:0]   w_acc_rnd;
    logic [64:0]   w_acc_prod;
    logic          w_clr_store, w_clr_table, w_tab_we;

    assign w_acc_rnd   = r_acc + 33'd256;
    assign w_acc_prod  = 65'(r_acc) * 65'(ExpStep);
    assign w_clr_store = ({1'b0, i_clr_addr} < (CW+1)'(NUM_SYNAPSES));
    assign w_clr_table = ({1'b0, i_clr_addr} < (CW+1)'(EXP_TABLE_DEPTH));
    assign w_tab_we    = i_cmd.clear && w_clr_table;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 33'h1_0000_0000;
        end else if (i_cmd.clear) begin
            r_acc <= w_acc_prod[64:32];
        end
    end

    assign w_in_range = ({{(32-stdp_pkg::SynW){1'b0}}, i_synapse} < 32'(NUM_SYNAPSES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_addr <= AW'(i_synapse);
            r_oor  <= !w_in_range;
            r_now  <= i_now_time;
        end
    end

    assign o_status.is_advance = (r_op == stdp_pkg::OP_ADVANCE) && !r_oor;

    stdp_ram #(.WIDTH(MW), .DEPTH(NUM_SYNAPSES)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(i_cmd.capture ? AW'(i_synapse) : r_addr),
        .o_rdata(w_rdata)
    );

    // one table copy per rate so all three factors come out in one read
    stdp_ram #(.WIDTH(TW), .DEPTH(EXP_TABLE_DEPTH)) u_exp_pre (
        .i_clk  (i_clk),
        .i_we   (w_tab_we),
        .i_waddr(EAW'(i_clr_addr)),
        .i_wdata(w_acc_rnd[9 +: TW]),
        .i_raddr(r_x_pre[18 +: EAW]),
        .o_rdata(w_tab_pre)
    );

    stdp_ram #(.WIDTH(TW), .DEPTH(EXP_TABLE_DEPTH)) u_exp_post (
        .i_clk  (i_clk),
        .i_we   (w_tab_we),
        .i_waddr(EAW'(i_clr_addr)),
        .i_wdata(w_acc_rnd[9 +: TW]),
        .i_raddr(r_x_post[18 +: EAW]),
        .o_rdata(w_tab_post)
    );

    stdp_ram #(.WIDTH(TW), .DEPTH(EXP_TABLE_DEPTH)) u_exp_elig (
        .i_clk  (i_clk),
        .i_we   (w_tab_we),
        .i_waddr(EAW'(i_clr_addr)),
        .i_wdata(w_acc_rnd[9 +: TW]),
        .i_raddr(r_x_elig[18 +: EAW]),
        .o_rdata(w_tab_elig)
    );

    assign w_elapsed = (r_now >= w_last) ? (r_now - w_last) : '0;

    // factor is zero past the end of the table
    assign w_f_pre  = r_big_pre  ? '0 : w_tab_pre;
    assign w_f_post = r_big_post ? '0 : w_tab_post;
    assign w_f_elig = r_big_elig ? '0 : w_tab_elig;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? stdp_pkg::TraceMax : s[TW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod) begin
            r_x_pre  <= PW'(w_elapsed) * PW'(i_pre_rate);
            r_x_post <= PW'(w_elapsed) * PW'(i_post_rate);
            r_x_elig <= PW'(w_elapsed) * PW'(i_elig_rate);
        end
        if (i_cmd.factor) begin
            r_big_pre  <= (r_x_pre[PW-1:18]  >= (PW-18)'(EXP_TABLE_DEPTH));
            r_big_post <= (r_x_post[PW-1:18] >= (PW-18)'(EXP_TABLE_DEPTH));
            r_big_elig <= (r_x_elig[PW-1:18] >= (PW-18)'(EXP_TABLE_DEPTH));
        end
        if (i_cmd.decay) begin
            r_d_pre  <= (2*TW)'(w_pre)  * (2*TW)'(w_f_pre);
            r_d_post <= (2*TW)'(w_post) * (2*TW)'(w_f_post);
            r_d_pp   <= (2*TW)'(w_pp)   * (2*TW)'(w_f_elig);
            r_d_ppr  <= (2*TW)'(w_ppr)  * (2*TW)'(w_f_elig);
        end
    end

    always_comb begin
        n_pre = w_pre;
        n_post = w_post;
        n_pp = w_pp;
        n_ppr = w_ppr;
        unique case (stdp_pkg::t_opcode'(r_op))
            stdp_pkg::OP_ADVANCE: begin
                n_pre  = r_d_pre[TW+22:23];
                n_post = r_d_post[TW+22:23];
                n_pp   = r_d_pp[TW+22:23];
                n_ppr  = r_d_ppr[TW+22:23];
            end
            stdp_pkg::OP_PRE: begin
                n_pre = sat_add(w_pre, stdp_pkg::OneQ816);
                n_ppr = sat_add(w_ppr, w_post);
            end
            stdp_pkg::OP_POST: begin
                n_post = sat_add(w_post, stdp_pkg::OneQ816);
                n_pp   = sat_add(w_pp, w_pre);
            end
            default: ;
        endcase
    end

    always_comb begin
        w_we    = (i_cmd.clear && w_clr_store) || (i_cmd.commit && !r_oor);
        w_waddr = i_cmd.clear ? AW'(i_clr_addr) : r_addr;
        w_wdata = i_cmd.clear ? '0 :
                  {((r_op == stdp_pkg::OP_ADVANCE) ? r_now : w_last),
                   n_pre, n_post, n_pp, n_ppr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pre <= '0;
        end else if (i_cmd.commit) begin
            o_pre <= r_oor ? '0 : n_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_post     <= r_oor ? '0 : n_post;
            o_pp_elig  <= r_oor ? '0 : n_pp;
            o_post_pre <= r_oor ? '0 : n_ppr;
        end
    end
endmodule
`default_nettype wire

>>> test/stdp_trace_checker.sv
`default_nettype none
module stdp_trace_checker
    import stdp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [95:0] m_axis_tdata,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [RateW-1:0]   i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NumSyn   = 1024;
    localparam int unsigned LutDepth = 1024;

    typedef struct packed {
        logic [TraceW-1:0] post_pre;
        logic [TraceW-1:0] pp_elig;
        logic [TraceW-1:0] post;
        logic [TraceW-1:0] pre;
    } t_traces;

    logic [TraceW-1:0] exp_lut [LutDepth];
    logic [TimeW-1:0]  syn_time [NumSyn];
    t_traces           syn_tr   [NumSyn];
    logic [RateW-1:0]  rate_pre, rate_post, rate_elig;
    t_traces           traces_due [$];

    // exp(-i/64) in Q1.23 from the Q.32 recurrence
    initial begin
        logic [95:0] acc;
        acc = 96'h1_0000_0000;
        for (int i = 0; i < LutDepth; i++) begin
            exp_lut[i] = 24'((acc + 96'd256) >> 9);
            acc = (acc * 96'd4228380000) >> 32;
        end
    end

    function automatic logic [TraceW-1:0] decay_factor(logic [TimeW-1:0] elapsed,
                                                       logic [RateW-1:0] rate);
        logic [55:0] x;
        logic [55:0] idx;
        x = 56'(elapsed) * 56'(rate);
        idx = x >> 18;
        if (idx >= LutDepth) return '0;
        return exp_lut[idx[9:0]];
    endfunction

    function automatic logic [TraceW-1:0] decayed(logic [TraceW-1:0] tr,
                                                  logic [TraceW-1:0] f);
        logic [47:0] p;
        p = 48'(tr) * 48'(f);
        return 24'(p >> 23);
    endfunction

    function automatic logic [TraceW-1:0] sat_sum(logic [TraceW-1:0] a,
                                                  logic [TraceW-1:0] b);
        logic [TraceW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TraceW] ? TraceMax : s[TraceW-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        o_errors++;
    endtask

    // apply one input transaction to the synapse state, return its traces
    function automatic t_traces update_synapse(logic [47:0] d);
        t_opcode op;
        int unsigned s;
        logic [TimeW-1:0] now, el;
        t_traces t;
        logic [TraceW-1:0] fe;
        op  = t_opcode'(d[1:0]);
        s   = d[11:2];
        now = d[43:12];
        t   = syn_tr[s];
        case (op)
            OP_ADVANCE: begin
                el = (now >= syn_time[s]) ? now - syn_time[s] : '0;
                fe = decay_factor(el, rate_elig);
                t.pre      = decayed(t.pre, decay_factor(el, rate_pre));
                t.post     = decayed(t.post, decay_factor(el, rate_post));
                t.pp_elig  = decayed(t.pp_elig, fe);
                t.post_pre = decayed(t.post_pre, fe);
                syn_time[s] = now;
            end
            OP_PRE: begin
                t.pre      = sat_sum(syn_tr[s].pre, OneQ816);
                t.post_pre = sat_sum(syn_tr[s].post_pre, syn_tr[s].post);
            end
            OP_POST: begin
                t.post     = sat_sum(syn_tr[s].post, OneQ816);
                t.pp_elig  = sat_sum(syn_tr[s].pp_elig, syn_tr[s].pre);
            end
            default: ;
        endcase
        syn_tr[s] = t;
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_traces want, got;
        if (!i_rst_n) begin
            rate_pre  <= 24'd16777;
            rate_post <= 24'd16777;
            rate_elig <= 24'd1678;
            for (int i = 0; i < NumSyn; i++) begin
                syn_time[i] = '0;
                syn_tr[i]   = '0;
            end
            traces_due.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (traces_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %024h", m_axis_tdata));
                end else begin
                    want = traces_due.pop_front();
                    o_checked++;
                    if (got.pre != want.pre)
                        report_mismatch($sformatf("pre_trace: expected %06h, got %06h",
                                                  want.pre, got.pre));
                    if (got.post != want.post)
                        report_mismatch($sformatf("post_trace: expected %06h, got %06h",
                                                  want.post, got.post));
                    if (got.pp_elig != want.pp_elig)
                        report_mismatch($sformatf(
                            "pre-before-post elig: expected %06h, got %06h",
                            want.pp_elig, got.pp_elig));
                    if (got.post_pre != want.post_pre)
                        report_mismatch($sformatf("post_pre_elig: expected %06h, got %06h",
                                                  want.post_pre, got.post_pre));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                traces_due.push_back(update_synapse(s_axis_tdata));
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PRE_RATE:  rate_pre  <= i_cfg_data;
                    CFG_POST_RATE: rate_post <= i_cfg_data;
                    CFG_ELIG_RATE: rate_elig <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = traces_due.size();
    end

endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
// Stimulus and verdict for stdp_eligibility_traces_core. The checker beside
// the DUT does all prediction and comparison.
module tb_top;
    import stdp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;  // covers the post-reset clearing pass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [RateW-1:0]   i_cfg_data = '0;

    int errors, pending, checked;
    int idle_cycles = 0;
    int n_items = 0;
    int n_cfg = 0;
    bit quiet = 1'b0;   // no gaps, no stalls while set
    int stall_left = 0;

    // per-synapse clock used for well-formed advance-time sequences
    logic [TimeW-1:0] tick_of [1024];
    logic [9:0] hot [8];

    always #5 i_clk = ~i_clk;

    stdp_eligibility_traces_core u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    stdp_trace_checker u_chk (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // result-side backpressure
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 15)
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 3);
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Watchdog expired after %0d idle cycles", IdleLimit);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(t_opcode op, logic [9:0] syn, logic [TimeW-1:0] now);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, now, syn, op};
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
    endtask

    // block is idle once every result is back; spikes never leave work behind
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_rate(t_cfg_idx idx, logic [RateW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        n_cfg++;
    endtask

    task automatic set_rates(logic [RateW-1:0] pre, logic [RateW-1:0] post,
                             logic [RateW-1:0] elig);
        wait_drained();
        write_rate(CFG_PRE_RATE, pre);
        write_rate(CFG_POST_RATE, post);
        write_rate(CFG_ELIG_RATE, elig);
    endtask

    // well-formed traffic on a few busy synapses, with some noise
    task automatic random_items(int count);
        int r;
        logic [9:0] s;
        logic [TimeW-1:0] t;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            s = hot[$urandom_range(0, 7)];
            if (r < 12) begin
                // noise: any opcode, synapse and time
                send_item(t_opcode'($urandom_range(0, 3)), 10'($urandom),
                          TimeW'($urandom));
            end else if (r < 50) begin
                r = $urandom_range(0, 99);
                if (r < 80)      t = tick_of[s] + $urandom_range(0, 40);
                else if (r < 90) t = tick_of[s] + $urandom_range(100, 5000);
                else if (r < 96) t = tick_of[s] - $urandom_range(1, 50);  // time going back
                else             t = TimeW'($urandom);
                tick_of[s] = t;
                send_item(OP_ADVANCE, s, t);
            end else if (r < 74) begin
                send_item(OP_PRE, s, TimeW'($urandom));
            end else if (r < 97) begin
                send_item(OP_POST, s, TimeW'($urandom));
            end else begin
                send_item(OP_NONE, s, TimeW'($urandom));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 1024; i++) tick_of[i] = '0;
        for (int i = 0; i < 8; i++) hot[i] = 10'($urandom);
        hot[0] = 10'd0;
        hot[1] = 10'd1023;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset rates
        send_item(OP_PRE, 10'd0, '0);
        send_item(OP_POST, 10'd0, '0);
        send_item(OP_PRE, 10'd0, '0);
        send_item(OP_ADVANCE, 10'd0, 32'd10);
        send_item(OP_ADVANCE, 10'd0, 32'd5);          // time going back
        send_item(OP_ADVANCE, 10'd0, 32'd5);          // zero elapsed
        send_item(OP_NONE, 10'd0, 32'hFFFF_FFFF);
        send_item(OP_POST, 10'd1023, '0);
        send_item(OP_PRE, 10'd1023, '0);
        send_item(OP_POST, 10'd1023, '0);
        send_item(OP_ADVANCE, 10'd1023, 32'hFFFF_FFFF); // factor beyond the table
        send_item(OP_ADVANCE, 10'd512, '0);
        send_item(OP_NONE, 10'd512, '0);
        send_item(OP_PRE, 10'd512, '0);
        send_item(OP_ADVANCE, 10'd512, 32'd60000);
        send_item(OP_ADVANCE, 10'd512, 32'd1);
        tick_of[0] = 32'd5;
        tick_of[1023] = 32'hFFFF_FFFF;
        tick_of[512] = 32'd1;

        random_items(50);

        // extremes of the rates: no decay at all, then total loss
        set_rates('0, '0, '0);
        write_rate(CFG_UNUSED, 24'hABCDEF);           // ignored index
        quiet = 1'b1;
        for (int k = 0; k < 30; k++) begin            // eligibility saturates
            send_item(OP_PRE, 10'd7, '0);
            send_item(OP_POST, 10'd7, '0);
        end
        quiet = 1'b0;
        for (int k = 0; k < 260; k++) send_item(OP_PRE, 10'd9, '0);  // pre saturates
        send_item(OP_ADVANCE, 10'd7, 32'hFFFF_FFFF);
        random_items(20);

        set_rates(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_item(OP_ADVANCE, 10'd9, 32'd1);
        send_item(OP_ADVANCE, 10'd7, 32'd0);
        random_items(20);

        set_rates(24'($urandom_range(1000, 300000)), 24'($urandom_range(1000, 300000)),
                  24'($urandom_range(100, 50000)));
        random_items(50);

        set_rates(24'($urandom), 24'($urandom), 24'($urandom));
        random_items(20);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d stream items and %0d register writes; %0d results compared.",
                 n_items, n_cfg, checked);
        $display("Rates went through reset values, zero, full scale and random settings.");
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, pending);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> stdp_eligibility_traces_core.f
rtl/stdp_pkg.sv
rtl/stdp_ram.sv
rtl/stdp_ctrl.sv
rtl/stdp_dp.sv
rtl/stdp_eligibility_traces_core.sv
test/stdp_trace_checker.sv
test/tb_top.sv
